[sv/wpss_pkg.sv]
// wpss_pkg: types, constants and helpers for the well plate stage sequencer
// used by well_plate_stage_sequencer; no dependencies
`timescale 1ns / 1ps

package wpss_pkg;

    localparam int WELLS_PER_BAND = 8;
    localparam int NUM_BANDS      = 4;
    localparam int NUM_WELLS      = WELLS_PER_BAND * NUM_BANDS;

    localparam int WELL_W = 6;
    localparam int TGT_W  = 24;
    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int SLOT_W = $clog2(WELLS_PER_BAND);

    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(NUM_BANDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WELLS_PER_BAND - 1);
    localparam logic [WELL_W-1:0] WELL_EJECT = WELL_W'(NUM_WELLS);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 72;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_ZERO   = 2'd2,
        KIND_REPLY  = 2'd3
    } kind_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JOG_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WELL_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_PITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_TOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_BOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EJECT_TOP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EJECT_BOT  = 3'd6;

    // register reset values
    localparam logic [7:0]         JOG_STEP_RST   = 8'd5;
    localparam logic [11:0]        WELL_PITCH_RST = 12'd225;
    localparam logic [13:0]        BAND_PITCH_RST = 14'd675;
    localparam logic signed [16:0] HOME_TOP_RST   = -17'sd4310;
    localparam logic signed [16:0] HOME_BOT_RST   = 17'sd2600;
    localparam logic signed [16:0] EJECT_TOP_RST  = 17'sd2025;
    localparam logic signed [16:0] EJECT_BOT_RST  = 17'sd900;

    // command characters
    localparam logic [7:0] CMD_IDENT   = 8'h3F; // '?'
    localparam logic [7:0] CMD_PATTERN = 8'h58; // 'X'
    localparam logic [7:0] CMD_HOME    = 8'h5A; // 'Z'
    localparam logic [7:0] CMD_NEXT    = 8'h4E; // 'N'
    localparam logic [7:0] CMD_PREV    = 8'h4C; // 'L'
    localparam logic [7:0] CMD_EJECT   = 8'h45; // 'E'
    localparam logic [7:0] CMD_TOP_UP  = 8'h55; // 'U'
    localparam logic [7:0] CMD_TOP_DN  = 8'h49; // 'I'
    localparam logic [7:0] CMD_BOT_UP  = 8'h4F; // 'O'
    localparam logic [7:0] CMD_BOT_DN  = 8'h50; // 'P'
    localparam logic [7:0] CMD_ZERO    = 8'h4D; // 'M'
    localparam logic [7:0] CMD_VA_OFF  = 8'h41; // 'A'
    localparam logic [7:0] CMD_VA_ON   = 8'h53; // 'S'
    localparam logic [7:0] CMD_VB_OFF  = 8'h44; // 'D'
    localparam logic [7:0] CMD_VB_ON   = 8'h46; // 'F'
    localparam logic [7:0] CMD_VC_OFF  = 8'h47; // 'G'
    localparam logic [7:0] CMD_VC_ON   = 8'h48; // 'H'

    // identity reply "2xCS"
    localparam logic [7:0] REPLY_0 = 8'h32;
    localparam logic [7:0] REPLY_1 = 8'h78;
    localparam logic [7:0] REPLY_2 = 8'h43;
    localparam logic [7:0] REPLY_3 = 8'h53;

    typedef struct packed {
        kind_t                    kind;
        logic                     busy;
        logic [2:0]               valves;
        logic [WELL_W-1:0]        well;
        logic [7:0]               reply;
        logic signed [TGT_W-1:0]  bottom;
        logic signed [TGT_W-1:0]  top;
    } item_t;

    // saturating add into the 24-bit signed target range
    function automatic logic signed [TGT_W-1:0] sat_add(
        input logic signed [TGT_W-1:0] a,
        input logic signed [17:0]      d
    );
        logic signed [TGT_W:0] s;
        s = {a[TGT_W-1], a} + {{(TGT_W-17){d[17]}}, d};
        if (s[TGT_W] != s[TGT_W-1]) begin
            return s[TGT_W] ? {1'b1, {(TGT_W-1){1'b0}}} : {1'b0, {(TGT_W-1){1'b1}}};
        end
        return s[TGT_W-1:0];
    endfunction

endpackage

[sv/well_plate_stage_sequencer.sv]
// well_plate_stage_sequencer: command and homing sequencer for a well plate stage
// depends on wpss_pkg (types, command codes, saturating add)
`timescale 1ns / 1ps

//  channel   dir   tdata / tuser                                    tlast
//  s_        in    rx_byte, top_switch_open, bottom_switch_open /   -
//                  cmd
//  m_        out   target_top, target_bottom, reply_byte,           last
//                  well_position, valve_a/b/c, homing_busy / kind
//  cfg_      in    write enable, register index, write data         -
//
// an item waits in the input register until the result buffer is free, then its
// results land in a four-entry result buffer; most items give one result, one per
// cycle unless m_ stalls; the identity reply gives four results and holds the
// buffer until all transfer; a new item loads in the cycle its last result transfers
// reset clears the state, the registers return to their defaults; no clearing pass
// a stall on m_ holds the buffer and, once the input register is full, s_tready

module well_plate_stage_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] rx_byte, [8] top_switch_open, [9] bottom_switch_open, [15:10] zero
    input  logic [wpss_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] cmd
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] target_top, [47:24] target_bottom, [55:48] reply_byte,
    // [61:56] well_position, [62] valve_a, [63] valve_b, [64] valve_c,
    // [65] homing_busy, [71:66] zero
    output logic [wpss_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] kind
    output logic [wpss_pkg::KIND_W-1:0]       m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [wpss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpss_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int TW = wpss_pkg::TGT_W;
    localparam int BW = wpss_pkg::BAND_W;
    localparam int SW = wpss_pkg::SLOT_W;
    localparam int WW = wpss_pkg::WELL_W;

    // configuration registers
    logic [7:0]         jog_step_reg;
    logic [11:0]        well_pitch_reg;
    logic [13:0]        band_pitch_reg;
    logic signed [16:0] home_top_reg;
    logic signed [16:0] home_bot_reg;
    logic signed [16:0] eject_top_reg;
    logic signed [16:0] eject_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jog_step_reg   <= wpss_pkg::JOG_STEP_RST;
            well_pitch_reg <= wpss_pkg::WELL_PITCH_RST;
            band_pitch_reg <= wpss_pkg::BAND_PITCH_RST;
            home_top_reg   <= wpss_pkg::HOME_TOP_RST;
            home_bot_reg   <= wpss_pkg::HOME_BOT_RST;
            eject_top_reg  <= wpss_pkg::EJECT_TOP_RST;
            eject_bot_reg  <= wpss_pkg::EJECT_BOT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wpss_pkg::REG_JOG_STEP:   jog_step_reg   <= cfg_wdata[7:0];
                wpss_pkg::REG_WELL_PITCH: well_pitch_reg <= cfg_wdata[11:0];
                wpss_pkg::REG_BAND_PITCH: band_pitch_reg <= cfg_wdata[13:0];
                wpss_pkg::REG_HOME_TOP:   home_top_reg   <= cfg_wdata;
                wpss_pkg::REG_HOME_BOT:   home_bot_reg   <= cfg_wdata;
                wpss_pkg::REG_EJECT_TOP:  eject_top_reg  <= cfg_wdata;
                wpss_pkg::REG_EJECT_BOT:  eject_bot_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] byte_reg;
    logic       top_open_reg;
    logic       bot_open_reg;

    // sequencer state
    logic [WW-1:0]    well_reg;
    logic [BW-1:0]    band_reg;
    logic [SW-1:0]    slot_reg;
    logic signed [TW-1:0] top_reg;
    logic signed [TW-1:0] bot_reg;
    logic             snake_reg;
    logic             homing_reg;
    logic [2:0]       valves_reg;

    // result buffer
    wpss_pkg::item_t  buf_reg [4];
    logic             out_valid_reg;
    logic [1:0]       out_ptr_reg;
    logic [1:0]       out_last_reg;

    logic out_xfer, out_done, load;

    assign out_xfer = out_valid_reg && m_tready;
    assign out_done = out_xfer && (out_ptr_reg == out_last_reg);
    assign load     = in_valid_reg && (!out_valid_reg || out_done);
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg      <= s_tuser[0];
            byte_reg     <= s_tdata[7:0];
            top_open_reg <= s_tdata[8];
            bot_open_reg <= s_tdata[9];
        end
    end

    // neighbor well selection for next and previous
    logic [BW-1:0] goto_band;
    logic [SW-1:0] goto_slot;
    logic [SW-1:0] goto_slot_eff;
    logic [BW+13:0] prod_top;
    logic [SW+11:0] prod_bot;
    logic signed [TW-1:0] goto_top;
    logic signed [TW-1:0] goto_bot;

    always_comb begin
        goto_band = band_reg;
        goto_slot = slot_reg;
        if (byte_reg == wpss_pkg::CMD_PREV) begin
            if (well_reg == wpss_pkg::WELL_EJECT) begin
                goto_band = wpss_pkg::BAND_LAST;
                goto_slot = wpss_pkg::SLOT_LAST;
            end else if (slot_reg == '0) begin
                goto_band = band_reg - BW'(1);
                goto_slot = wpss_pkg::SLOT_LAST;
            end else begin
                goto_slot = slot_reg - SW'(1);
            end
        end else begin
            if (slot_reg == wpss_pkg::SLOT_LAST) begin
                goto_band = band_reg + BW'(1);
                goto_slot = '0;
            end else begin
                goto_slot = slot_reg + SW'(1);
            end
        end
    end

    // odd bands run backwards in snake pattern
    assign goto_slot_eff = (snake_reg && goto_band[0]) ? (wpss_pkg::SLOT_LAST - goto_slot)
                                                       : goto_slot;
    assign prod_top = (BW+14)'(goto_band) * (BW+14)'(band_pitch_reg);
    assign prod_bot = (SW+12)'(goto_slot_eff) * (SW+12)'(well_pitch_reg);
    assign goto_top = TW'(prod_top);
    assign goto_bot = TW'(0) - TW'(prod_bot);

    // per-item decode
    logic [WW-1:0]        well_next;
    logic [BW-1:0]        band_next;
    logic [SW-1:0]        slot_next;
    logic signed [TW-1:0] top_next;
    logic signed [TW-1:0] bot_next;
    logic                 snake_next;
    logic                 homing_next;
    logic [2:0]           valves_next;
    logic signed [TW-1:0] mid_top;
    logic signed [TW-1:0] mid_bot;
    logic [WW-1:0]        mid_well;
    logic                 mid_busy;
    logic                 mid_used;
    wpss_pkg::kind_t      kind0;
    logic [1:0]           last_next;
    logic                 is_ident;
    logic [WW:0]          well_inc;
    logic signed [17:0]   jog_pos;
    logic signed [17:0]   jog_neg;
    wpss_pkg::item_t      items [4];

    assign well_inc = {1'b0, well_reg} + (WW+1)'(1);
    assign jog_pos  = {10'b0, jog_step_reg};
    assign jog_neg  = 18'sd0 - jog_pos;

    always_comb begin
        well_next   = well_reg;
        band_next   = band_reg;
        slot_next   = slot_reg;
        top_next    = top_reg;
        bot_next    = bot_reg;
        snake_next  = snake_reg;
        homing_next = homing_reg;
        valves_next = valves_reg;
        mid_top     = top_reg;
        mid_bot     = bot_reg;
        mid_well    = well_reg;
        mid_busy    = homing_reg;
        mid_used    = 1'b0;
        kind0       = wpss_pkg::KIND_STATUS;
        last_next   = 2'd0;
        is_ident    = 1'b0;
        if (cmd_reg) begin
            if (homing_reg) begin
                if (top_open_reg || bot_open_reg) begin
                    kind0 = wpss_pkg::KIND_MOVE;
                    if (top_open_reg) top_next = wpss_pkg::sat_add(top_reg, 18'sd1);
                    if (bot_open_reg) bot_next = wpss_pkg::sat_add(bot_reg, -18'sd1);
                end else begin
                    // both pressed: offset move, then origin re-zero
                    kind0       = wpss_pkg::KIND_MOVE;
                    mid_used    = 1'b1;
                    mid_top     = wpss_pkg::sat_add(top_reg, {home_top_reg[16], home_top_reg});
                    mid_bot     = wpss_pkg::sat_add(bot_reg, {home_bot_reg[16], home_bot_reg});
                    homing_next = 1'b0;
                    well_next   = '0;
                    band_next   = '0;
                    slot_next   = '0;
                    top_next    = '0;
                    bot_next    = '0;
                    last_next   = 2'd1;
                end
            end
        end else if (!homing_reg) begin
            unique case (byte_reg)
                wpss_pkg::CMD_IDENT: begin
                    kind0     = wpss_pkg::KIND_REPLY;
                    is_ident  = 1'b1;
                    last_next = 2'd3;
                end
                wpss_pkg::CMD_PATTERN: snake_next  = !snake_reg;
                wpss_pkg::CMD_HOME:    homing_next = 1'b1;
                wpss_pkg::CMD_NEXT: begin
                    if (well_inc < (WW+1)'(wpss_pkg::NUM_WELLS)) begin
                        kind0     = wpss_pkg::KIND_MOVE;
                        well_next = well_inc[WW-1:0];
                        band_next = goto_band;
                        slot_next = goto_slot;
                        top_next  = goto_top;
                        bot_next  = goto_bot;
                    end
                end
                wpss_pkg::CMD_PREV: begin
                    if (well_reg != '0) begin
                        kind0     = wpss_pkg::KIND_MOVE;
                        well_next = well_reg - WW'(1);
                        band_next = goto_band;
                        slot_next = goto_slot;
                        top_next  = goto_top;
                        bot_next  = goto_bot;
                    end
                end
                wpss_pkg::CMD_EJECT: begin
                    kind0     = wpss_pkg::KIND_MOVE;
                    well_next = wpss_pkg::WELL_EJECT;
                    top_next  = {{(TW-17){eject_top_reg[16]}}, eject_top_reg};
                    bot_next  = {{(TW-17){eject_bot_reg[16]}}, eject_bot_reg};
                end
                wpss_pkg::CMD_TOP_UP: begin
                    kind0    = wpss_pkg::KIND_MOVE;
                    top_next = wpss_pkg::sat_add(top_reg, jog_pos);
                end
                wpss_pkg::CMD_TOP_DN: begin
                    kind0    = wpss_pkg::KIND_MOVE;
                    top_next = wpss_pkg::sat_add(top_reg, jog_neg);
                end
                wpss_pkg::CMD_BOT_UP: begin
                    kind0    = wpss_pkg::KIND_MOVE;
                    bot_next = wpss_pkg::sat_add(bot_reg, jog_pos);
                end
                wpss_pkg::CMD_BOT_DN: begin
                    kind0    = wpss_pkg::KIND_MOVE;
                    bot_next = wpss_pkg::sat_add(bot_reg, jog_neg);
                end
                wpss_pkg::CMD_ZERO: begin
                    kind0     = wpss_pkg::KIND_ZERO;
                    well_next = '0;
                    band_next = '0;
                    slot_next = '0;
                    top_next  = '0;
                    bot_next  = '0;
                end
                wpss_pkg::CMD_VA_OFF: valves_next[0] = 1'b0;
                wpss_pkg::CMD_VA_ON:  valves_next[0] = 1'b1;
                wpss_pkg::CMD_VB_OFF: valves_next[1] = 1'b0;
                wpss_pkg::CMD_VB_ON:  valves_next[1] = 1'b1;
                wpss_pkg::CMD_VC_OFF: valves_next[2] = 1'b0;
                wpss_pkg::CMD_VC_ON:  valves_next[2] = 1'b1;
                default: ;
            endcase
        end
        if (!mid_used) begin
            mid_top  = top_next;
            mid_bot  = bot_next;
            mid_well = well_next;
            mid_busy = homing_next;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            items[k].kind   = is_ident ? wpss_pkg::KIND_REPLY : wpss_pkg::KIND_ZERO;
            items[k].busy   = homing_next;
            items[k].valves = valves_next;
            items[k].well   = well_next;
            items[k].reply  = '0;
            items[k].bottom = bot_next;
            items[k].top    = top_next;
        end
        items[0].kind  = kind0;
        items[0].busy  = mid_busy;
        items[0].well  = mid_well;
        items[0].top   = mid_top;
        items[0].bottom = mid_bot;
        if (is_ident) begin
            items[0].reply = wpss_pkg::REPLY_0;
            items[1].reply = wpss_pkg::REPLY_1;
            items[2].reply = wpss_pkg::REPLY_2;
            items[3].reply = wpss_pkg::REPLY_3;
        end
    end

    // state and result buffer update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            well_reg      <= '0;
            band_reg      <= '0;
            slot_reg      <= '0;
            top_reg       <= '0;
            bot_reg       <= '0;
            snake_reg     <= 1'b1;
            homing_reg    <= 1'b0;
            valves_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_ptr_reg   <= '0;
            out_last_reg  <= '0;
        end else if (load) begin
            well_reg      <= well_next;
            band_reg      <= band_next;
            slot_reg      <= slot_next;
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            snake_reg     <= snake_next;
            homing_reg    <= homing_next;
            valves_reg    <= valves_next;
            out_valid_reg <= 1'b1;
            out_ptr_reg   <= '0;
            out_last_reg  <= last_next;
        end else if (out_done) begin
            out_valid_reg <= 1'b0;
        end else if (out_xfer) begin
            out_ptr_reg   <= out_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < 4; k++) begin
                buf_reg[k] <= items[k];
            end
        end
    end

    wpss_pkg::item_t cur;
    assign cur = buf_reg[out_ptr_reg];

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = (out_ptr_reg == out_last_reg);
    assign m_tuser  = cur.kind;
    assign m_tdata  = {6'b0, cur.busy, cur.valves, cur.well, cur.reply, cur.bottom, cur.top};

    // checks
    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_ptr_reg <= out_last_reg))
        else $error("result pointer past last entry");

    a_four_only_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg == 2'd3) |-> (buf_reg[0].kind == wpss_pkg::KIND_REPLY))
        else $error("four-result burst that is not the identity reply");

    a_zero_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == wpss_pkg::KIND_ZERO) |-> m_tlast)
        else $error("zero origin result not final");

    a_byte_in_homing_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && homing_reg && !cmd_reg) |=>
            (top_reg == $past(top_reg) && bot_reg == $past(bot_reg)
             && well_reg == $past(well_reg)))
        else $error("byte during homing changed the stage state");

    a_well_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        well_reg <= wpss_pkg::WELL_EJECT)
        else $error("well index beyond eject");

endmodule

[dv/well_plate_stage_sequencer_test.sv]
// well_plate_stage_sequencer_test: self-checking bench for the stage sequencer, a directed
// table then random command traffic and a homing offset sweep under mixed idling
// depends on wpss_pkg and well_plate_stage_sequencer
`timescale 1ns / 1ps

module well_plate_stage_sequencer_test;
    import wpss_pkg::*;

    localparam int TGT_MAX     = 8388607;
    localparam int TGT_MIN     = -8388608;
    localparam int STALL_LIMIT = 1000;
    // no register lives at this index
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        kind_t       kind;
        int          top;
        int          bottom;
        logic [7:0]  reply;
        logic [5:0]  well;
        logic [2:0]  valves;
        logic        busy;
        logic        last;
    } stage_result_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  rx;
        logic        top_open;
        logic        bot_open;
        logic        typed;
        kind_t       kind;
        int          top;
        int          bottom;
        int          well;
        logic [7:0]  reply;
    } directed_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [KIND_W-1:0]       m_tuser;
    logic                    m_tlast;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    // stage state as the bench sees it
    int          plate_well = 0;
    int          plate_top = 0;
    int          plate_bottom = 0;
    logic        snake_on = 1'b1;
    logic        homing_on = 1'b0;
    logic [2:0]  valve_state = 3'b000;
    int          jog_size = JOG_STEP_RST;
    int          pitch_well = WELL_PITCH_RST;
    int          pitch_band = BAND_PITCH_RST;
    int          home_top = HOME_TOP_RST;
    int          home_bot = HOME_BOT_RST;
    int          eject_top_pos = EJECT_TOP_RST;
    int          eject_bot_pos = EJECT_BOT_RST;

    stage_result_t pending_results [$];
    stage_result_t lead;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int items_in = 0;
    int results_out = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    directed_row_t steps [25] = '{
        '{1'b1, 8'hA5,       1'b1, 1'b1, 1'b1, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_IDENT,   1'b0, 1'b1, 1'b1, KIND_REPLY,  0,    0,    0,  REPLY_0},
        '{1'b0, CMD_PREV,    1'b1, 1'b0, 1'b1, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_NEXT,    1'b0, 1'b0, 1'b1, KIND_MOVE,   0,    -225, 1,  8'h00},
        '{1'b0, CMD_PATTERN, 1'b1, 1'b1, 1'b1, KIND_STATUS, 0,    -225, 1,  8'h00},
        '{1'b0, CMD_EJECT,   1'b0, 1'b1, 1'b1, KIND_MOVE,   2025, 900,  32, 8'h00},
        '{1'b0, CMD_NEXT,    1'b1, 1'b0, 1'b1, KIND_STATUS, 2025, 900,  32, 8'h00},
        '{1'b0, CMD_ZERO,    1'b0, 1'b0, 1'b1, KIND_ZERO,   0,    0,    0,  8'h00},
        '{1'b0, CMD_TOP_UP,  1'b1, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_TOP_DN,  1'b0, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_BOT_UP,  1'b1, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_BOT_DN,  1'b0, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VA_ON,   1'b1, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VB_ON,   1'b0, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VC_ON,   1'b1, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VA_OFF,  1'b0, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VB_OFF,  1'b1, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_VC_OFF,  1'b0, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, 8'hFF,       1'b1, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_HOME,    1'b0, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b0, CMD_NEXT,    1'b1, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b1, 8'h00,       1'b1, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b1, 8'h5A,       1'b0, 1'b1, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b1, 8'hC3,       1'b1, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00},
        '{1'b1, 8'h3C,       1'b0, 1'b0, 1'b0, KIND_STATUS, 0,    0,    0,  8'h00}
    };

    well_plate_stage_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int clamp24(longint v);
        if (v > TGT_MAX) return TGT_MAX;
        if (v < TGT_MIN) return TGT_MIN;
        return int'(v);
    endfunction

    // well coordinates by formula, odd bands reversed in snake pattern
    function automatic void place_at(int idx);
        int band;
        int slot;
        if (idx >= NUM_WELLS) begin
            plate_top = clamp24(eject_top_pos);
            plate_bottom = clamp24(eject_bot_pos);
            return;
        end
        band = idx / WELLS_PER_BAND;
        slot = idx % WELLS_PER_BAND;
        if (snake_on && (band % 2 == 1)) slot = WELLS_PER_BAND - 1 - slot;
        plate_top = clamp24(longint'(band) * pitch_band);
        plate_bottom = clamp24(-(longint'(slot) * pitch_well));
    endfunction

    function automatic stage_result_t snapshot(kind_t k, logic [7:0] reply);
        stage_result_t r;
        r.kind = k;
        r.top = plate_top;
        r.bottom = plate_bottom;
        r.reply = reply;
        r.well = 6'(plate_well);
        r.valves = valve_state;
        r.busy = homing_on;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void predict_stage_step(input logic cmd, input logic [7:0] rx,
            input logic top_open, input logic bot_open, output stage_result_t head);
        stage_result_t res [4];
        kind_t k;
        logic [7:0] tail_reply;
        int n;
        k = KIND_STATUS;
        tail_reply = 8'h00;
        n = 0;
        if (cmd) begin
            if (homing_on && !(top_open || bot_open)) begin
                plate_top = clamp24(longint'(plate_top) + home_top);
                plate_bottom = clamp24(longint'(plate_bottom) + home_bot);
                res[0] = snapshot(KIND_MOVE, 8'h00);
                n = 1;
                homing_on = 1'b0;
                plate_well = 0;
                place_at(0);
                k = KIND_ZERO;
            end else if (homing_on) begin
                if (top_open) plate_top = clamp24(longint'(plate_top) + 1);
                if (bot_open) plate_bottom = clamp24(longint'(plate_bottom) - 1);
                k = KIND_MOVE;
            end
        end else if (!homing_on) begin
            case (rx)
                CMD_IDENT: begin
                    res[0] = snapshot(KIND_REPLY, REPLY_0);
                    res[1] = snapshot(KIND_REPLY, REPLY_1);
                    res[2] = snapshot(KIND_REPLY, REPLY_2);
                    n = 3;
                    k = KIND_REPLY;
                    tail_reply = REPLY_3;
                end
                CMD_PATTERN: snake_on = !snake_on;
                CMD_HOME:    homing_on = 1'b1;
                CMD_NEXT: begin
                    if (plate_well + 1 < NUM_WELLS) begin
                        plate_well++;
                        place_at(plate_well);
                        k = KIND_MOVE;
                    end
                end
                CMD_PREV: begin
                    if (plate_well > 0) begin
                        plate_well--;
                        place_at(plate_well);
                        k = KIND_MOVE;
                    end
                end
                CMD_EJECT: begin
                    plate_well = NUM_WELLS;
                    place_at(plate_well);
                    k = KIND_MOVE;
                end
                CMD_TOP_UP: begin
                    plate_top = clamp24(longint'(plate_top) + jog_size);
                    k = KIND_MOVE;
                end
                CMD_TOP_DN: begin
                    plate_top = clamp24(longint'(plate_top) - jog_size);
                    k = KIND_MOVE;
                end
                CMD_BOT_UP: begin
                    plate_bottom = clamp24(longint'(plate_bottom) + jog_size);
                    k = KIND_MOVE;
                end
                CMD_BOT_DN: begin
                    plate_bottom = clamp24(longint'(plate_bottom) - jog_size);
                    k = KIND_MOVE;
                end
                CMD_ZERO: begin
                    plate_well = 0;
                    place_at(0);
                    k = KIND_ZERO;
                end
                CMD_VA_OFF: valve_state[0] = 1'b0;
                CMD_VA_ON:  valve_state[0] = 1'b1;
                CMD_VB_OFF: valve_state[1] = 1'b0;
                CMD_VB_ON:  valve_state[1] = 1'b1;
                CMD_VC_OFF: valve_state[2] = 1'b0;
                CMD_VC_ON:  valve_state[2] = 1'b1;
                default: ;
            endcase
        end
        res[n] = snapshot(k, tail_reply);
        res[n].last = 1'b1;
        for (int i = 0; i <= n; i++) pending_results.push_back(res[i]);
        head = res[0];
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        stage_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_out++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending, kind %0d", m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("target_top", want.top, $signed(m_tdata[23:0]));
                check_field("target_bottom", want.bottom, $signed(m_tdata[47:24]));
                check_field("reply_byte", want.reply, m_tdata[55:48]);
                check_field("well_position", want.well, m_tdata[61:56]);
                check_field("valve_a", want.valves[0], m_tdata[62]);
                check_field("valve_b", want.valves[1], m_tdata[63]);
                check_field("valve_c", want.valves[2], m_tdata[64]);
                check_field("homing_busy", want.busy, m_tdata[65]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic cmd, input logic [7:0] rx,
            input logic top_open, input logic bot_open, output stage_result_t head);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'b0, bot_open, top_open, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_stage_step(cmd, rx, top_open, bot_open, head);
        items_in++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(1'b0, rx, 1'($urandom), 1'($urandom), lead);
    endtask

    task automatic send_tick(input logic top_open, input logic bot_open);
        send_item(1'b1, 8'($urandom), top_open, bot_open, lead);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // leaves cfg_we high; load_settings lowers it once at the end
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_JOG_STEP:   jog_size = data[7:0];
            REG_WELL_PITCH: pitch_well = data[11:0];
            REG_BAND_PITCH: pitch_band = data[13:0];
            REG_HOME_TOP:   home_top = $signed(data);
            REG_HOME_BOT:   home_bot = $signed(data);
            REG_EJECT_TOP:  eject_top_pos = $signed(data);
            REG_EJECT_BOT:  eject_bot_pos = $signed(data);
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
    endtask

    task automatic load_settings(input int jog, input int wp, input int bp,
            input int ht, input int hb, input int et, input int eb);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(REG_JOG_STEP, {junk[16:8], 8'(jog)});
        junk = CFG_W'($urandom);
        write_reg(REG_WELL_PITCH, {junk[16:12], 12'(wp)});
        junk = CFG_W'($urandom);
        write_reg(REG_BAND_PITCH, {junk[16:14], 14'(bp)});
        write_reg(REG_HOME_TOP, CFG_W'(ht));
        write_reg(REG_HOME_BOT, CFG_W'(hb));
        write_reg(REG_EJECT_TOP, CFG_W'(et));
        write_reg(REG_EJECT_BOT, CFG_W'(eb));
        write_reg(REG_NONE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_random_settings();
        load_settings($urandom_range(1, 255), $urandom_range(1, 4095),
                      $urandom_range(1, 16383), int'($urandom_range(131071)) - 65536,
                      int'($urandom_range(131071)) - 65536,
                      int'($urandom_range(131071)) - 65536,
                      int'($urandom_range(131071)) - 65536);
    endtask

    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            case ($urandom_range(6))
                0, 1, 2: send_byte(CMD_NEXT);
                3, 4:    send_byte(CMD_PREV);
                5:       send_byte(CMD_EJECT);
                default: send_byte(CMD_ZERO);
            endcase
        end else if (pick < 40) begin
            // plate scan from the origin, sometimes back again
            send_byte(CMD_ZERO);
            n = $urandom_range(1, 34);
            repeat (n) send_byte(CMD_NEXT);
            if ($urandom_range(1) == 1) begin
                n = $urandom_range(1, 34);
                repeat (n) send_byte(CMD_PREV);
            end
        end else if (pick < 55) begin
            case ($urandom_range(3))
                0:       send_byte(CMD_TOP_UP);
                1:       send_byte(CMD_TOP_DN);
                2:       send_byte(CMD_BOT_UP);
                default: send_byte(CMD_BOT_DN);
            endcase
        end else if (pick < 65) begin
            case ($urandom_range(5))
                0:       send_byte(CMD_VA_OFF);
                1:       send_byte(CMD_VA_ON);
                2:       send_byte(CMD_VB_OFF);
                3:       send_byte(CMD_VB_ON);
                4:       send_byte(CMD_VC_OFF);
                default: send_byte(CMD_VC_ON);
            endcase
        end else if (pick < 70) begin
            send_byte(CMD_IDENT);
        end else if (pick < 75) begin
            send_byte(CMD_PATTERN);
        end else if (pick < 90) begin
            // homing search, now and then a stray byte or no final close
            send_byte(CMD_HOME);
            n = $urandom_range(0, 6);
            repeat (n) begin
                if ($urandom_range(9) == 0) begin
                    send_byte(8'($urandom));
                end else begin
                    case ($urandom_range(2))
                        0:       send_tick(1'b0, 1'b1);
                        1:       send_tick(1'b1, 1'b0);
                        default: send_tick(1'b1, 1'b1);
                    endcase
                end
            end
            if ($urandom_range(9) != 0) send_tick(1'b0, 1'b0);
        end else begin
            send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), lead);
        end
    endtask

    task automatic run_random(input int budget, input int s_idle, input int r_stall);
        int start;
        logic paused;
        start = items_in;
        paused = 1'b0;
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        while (items_in - start < budget) begin
            if (!paused && items_in - start >= budget / 2) begin
                drain();
                paused = 1'b1;
            end
            random_sequence();
        end
        drain();
    endtask

    // jog off the origin, then run homing with the offsets at both ends of their range
    task automatic offset_sweep();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_settings(255, $urandom_range(1, 4095), $urandom_range(1, 16383), 65535, -65536,
                      int'($urandom_range(131071)) - 65536,
                      int'($urandom_range(131071)) - 65536);
        if (homing_on) send_tick(1'b0, 1'b0);
        send_byte(CMD_ZERO);
        repeat (3) begin
            send_byte(CMD_TOP_UP);
            send_byte(CMD_BOT_DN);
        end
        send_byte(CMD_HOME);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (3) begin
            send_byte(CMD_TOP_DN);
            send_byte(CMD_BOT_UP);
        end
        drain();
        load_settings(255, pitch_well, pitch_band, -65536, 65535, eject_top_pos, eject_bot_pos);
        send_byte(CMD_HOME);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();
    endtask

    initial begin : stimulus
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 25; i++) begin
            send_item(steps[i].cmd, steps[i].rx, steps[i].top_open, steps[i].bot_open, lead);
            if (steps[i].typed) begin
                check_field("kind", steps[i].kind, lead.kind);
                check_field("target_top", steps[i].top, lead.top);
                check_field("target_bottom", steps[i].bottom, lead.bottom);
                check_field("well_position", steps[i].well, lead.well);
                check_field("reply_byte", steps[i].reply, lead.reply);
            end
        end
        drain();

        load_settings(1, 1, 1, -65536, -65536, -65536, -65536);
        run_random(50, 0, 0);
        load_settings(255, 4095, 16383, 65535, 65535, 65535, 65535);
        run_random(50, 69, 0);
        load_random_settings();
        run_random(50, 0, 69);
        load_random_settings();
        run_random(50, 35, 35);
        offset_sweep();
        repeat (8) @(negedge aclk);

        $display("%0d command and tick transfers, %0d result transfers, %0d register writes",
                 items_in, results_out, reg_writes);
        $display("covered pitch and offset extremes, four idle mixes and homing at both offsets");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
